// ----- rtl/core/c2p_pkg.sv -----
// ----------------------------------------------------------------------------
// Cartesian to polar package
// Shared word types, field widths, fixed-point constants and the arctangent
// table used by the cartesian to polar conversion pipeline.
// ----------------------------------------------------------------------------
package c2p_pkg;

    localparam int COORD_WIDTH_DEF     = 16;
    localparam int ROTATION_STAGES_DEF = 16;

    localparam int FIELD_WIDTH  = 16;
    localparam int RADIUS_WIDTH = 16;
    localparam int ANGLE_WIDTH  = 17;

    // Angle accumulator: 2^16 units per degree.
    localparam int CORDIC_GUARD = 16;
    localparam int Z_WIDTH      = 25;
    localparam int FULL_WIDTH   = 25;

    localparam logic [FULL_WIDTH-1:0] DEG_90  = FULL_WIDTH'(90 * 65536);
    localparam logic [FULL_WIDTH-1:0] DEG_180 = FULL_WIDTH'(180 * 65536);
    localparam logic [FULL_WIDTH-1:0] DEG_270 = FULL_WIDTH'(270 * 65536);
    localparam logic [FULL_WIDTH-1:0] DEG_360 = FULL_WIDTH'(360 * 65536);

    localparam logic [FULL_WIDTH:0]    ROUND_HALF = (FULL_WIDTH+1)'(128);
    localparam logic [ANGLE_WIDTH:0]   ANGLE_WRAP = (ANGLE_WIDTH+1)'(360 * 256);

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] x_coord;
        logic signed [FIELD_WIDTH-1:0] y_coord;
    } t_in_word;

    typedef struct packed {
        logic [RADIUS_WIDTH-1:0] radius;
        logic [ANGLE_WIDTH-1:0]  angle_deg;
    } t_out_word;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic x_zero;
        logic y_zero;
    } t_quad;

    // round(atan(2^-i) * 180/pi * 2^16)
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] v;
        unique case (idx)
            0:       v = 32'd2949120;
            1:       v = 32'd1740967;
            2:       v = 32'd919879;
            3:       v = 32'd466945;
            4:       v = 32'd234379;
            5:       v = 32'd117304;
            6:       v = 32'd58666;
            7:       v = 32'd29335;
            8:       v = 32'd14668;
            9:       v = 32'd7334;
            10:      v = 32'd3667;
            11:      v = 32'd1833;
            12:      v = 32'd917;
            13:      v = 32'd458;
            14:      v = 32'd229;
            15:      v = 32'd115;
            16:      v = 32'd57;
            17:      v = 32'd29;
            18:      v = 32'd14;
            19:      v = 32'd7;
            20:      v = 32'd4;
            21:      v = 32'd2;
            22:      v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/c2p_cell.sv -----
// ----------------------------------------------------------------------------
// Cartesian to polar pipeline cell
// One link of the chain: a CORDIC vectoring micro-rotation and one digit of
// the integer square root when in range, with its own valid bit and hand-off.
// ----------------------------------------------------------------------------
module c2p_cell #(
    parameter int COORD_WIDTH     = c2p_pkg::COORD_WIDTH_DEF,
    parameter int ROTATION_STAGES = c2p_pkg::ROTATION_STAGES_DEF,
    parameter int CELL_INDEX      = 0
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_valid,
    output logic                                                 o_ready,
    input  logic signed [COORD_WIDTH+c2p_pkg::CORDIC_GUARD+1:0]  i_cx,
    input  logic signed [COORD_WIDTH+c2p_pkg::CORDIC_GUARD+1:0]  i_cy,
    input  logic signed [c2p_pkg::Z_WIDTH-1:0]                   i_z,
    input  logic [2*COORD_WIDTH:0]                               i_rem,
    input  logic [2*COORD_WIDTH:0]                               i_res,
    input  c2p_pkg::t_quad                                       i_quad,
    output logic                                                 o_valid,
    input  logic                                                 i_ready,
    output logic signed [COORD_WIDTH+c2p_pkg::CORDIC_GUARD+1:0]  o_cx,
    output logic signed [COORD_WIDTH+c2p_pkg::CORDIC_GUARD+1:0]  o_cy,
    output logic signed [c2p_pkg::Z_WIDTH-1:0]                   o_z,
    output logic [2*COORD_WIDTH:0]                               o_rem,
    output logic [2*COORD_WIDTH:0]                               o_res,
    output c2p_pkg::t_quad                                       o_quad
);

    localparam int XW = COORD_WIDTH + c2p_pkg::CORDIC_GUARD + 2;
    localparam int SW = 2 * COORD_WIDTH + 1;
    localparam int ZW = c2p_pkg::Z_WIDTH;

    localparam bit DO_ROT   = CELL_INDEX < ROTATION_STAGES;
    localparam bit DO_SQ    = CELL_INDEX < COORD_WIDTH;
    localparam int SQ_SHIFT = DO_SQ ? 2 * (COORD_WIDTH - 1 - CELL_INDEX) : 0;

    localparam logic [31:0]          ATAN_FULL = c2p_pkg::atan_entry(CELL_INDEX);
    localparam logic signed [ZW-1:0] ATAN      = ATAN_FULL[ZW-1:0];
    localparam logic [SW-1:0]        SQ_BIT    = SW'(1) << SQ_SHIFT;

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [XW-1:0] n_cx;
    logic signed [XW-1:0] n_cy;
    logic signed [ZW-1:0] n_z;
    logic [SW-1:0]        trial;
    logic [SW-1:0]        n_rem;
    logic [SW-1:0]        n_res;

    logic                 r_valid;
    logic signed [XW-1:0] r_cx;
    logic signed [XW-1:0] r_cy;
    logic signed [ZW-1:0] r_z;
    logic [SW-1:0]        r_rem;
    logic [SW-1:0]        r_res;
    c2p_pkg::t_quad       r_quad;

    always_comb begin
        dx    = i_cy >>> CELL_INDEX;
        dy    = i_cx >>> CELL_INDEX;
        n_cx  = i_cx;
        n_cy  = i_cy;
        n_z   = i_z;
        if (DO_ROT) begin
            if (!i_cy[XW-1]) begin
                n_cx = i_cx + dx;
                n_cy = i_cy - dy;
                n_z  = i_z + ATAN;
            end else begin
                n_cx = i_cx - dx;
                n_cy = i_cy + dy;
                n_z  = i_z - ATAN;
            end
        end
        trial = i_res + SQ_BIT;
        n_rem = i_rem;
        n_res = i_res;
        if (DO_SQ) begin
            if (i_rem >= trial) begin
                n_rem = i_rem - trial;
                n_res = (i_res >> 1) + SQ_BIT;
            end else begin
                n_res = i_res >> 1;
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_z    <= n_z;
            r_rem  <= n_rem;
            r_res  <= n_res;
            r_quad <= i_quad;
        end
    end

    assign o_valid = r_valid;
    assign o_cx    = r_cx;
    assign o_cy    = r_cy;
    assign o_z     = r_z;
    assign o_rem   = r_rem;
    assign o_res   = r_res;
    assign o_quad  = r_quad;

endmodule

// ----- rtl/core/cartesian_to_polar_degrees_unit.sv -----
// ----------------------------------------------------------------------------
// Cartesian to polar conversion in degrees
// Converts a signed point (x, y) to its rounded radius and its angle in
// degrees over [0, 360) with 8 fractional bits.
//
// The input channel takes one word of two signed coordinates; the output
// channel gives one word of radius and angle for each input word, in order.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low.
// The pipeline has three front stages (magnitudes, squares, sum of squares),
// one cell per CORDIC micro-rotation and square root digit, and the output
// register. Throughput is one word per cycle while the output is not stalled;
// every stage holds its own valid bit, so a stalled output only stops the
// stages behind it once they are full, and empty stages keep taking words.
// Synchronous reset empties every stage; the output valid goes low and no
// word in flight is delivered. While the receiver stalls, the output word
// is held unchanged.
// ----------------------------------------------------------------------------
module cartesian_to_polar_degrees_unit #(
    parameter int COORD_WIDTH     = c2p_pkg::COORD_WIDTH_DEF,
    parameter int ROTATION_STAGES = c2p_pkg::ROTATION_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  c2p_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output c2p_pkg::t_out_word o_data
);

    localparam int CW = COORD_WIDTH;
    localparam int XW = CW + c2p_pkg::CORDIC_GUARD + 2;
    localparam int SW = 2 * CW + 1;
    localparam int ZW = c2p_pkg::Z_WIDTH;
    localparam int FW = c2p_pkg::FULL_WIDTH;
    localparam int AW = c2p_pkg::ANGLE_WIDTH;
    localparam int EW = (CW > c2p_pkg::FIELD_WIDTH) ? CW : c2p_pkg::FIELD_WIDTH;
    localparam int NC = (CW > ROTATION_STAGES) ? CW : ROTATION_STAGES;

    // Input extraction
    logic [EW-1:0]  x_ext;
    logic [EW-1:0]  y_ext;
    logic [CW-1:0]  x_raw;
    logic [CW-1:0]  y_raw;
    logic [CW-1:0]  x_mag;
    logic [CW-1:0]  y_mag;
    c2p_pkg::t_quad in_quad;

    assign x_ext = EW'($unsigned(i_data.x_coord));
    assign y_ext = EW'($unsigned(i_data.y_coord));
    assign x_raw = x_ext[CW-1:0];
    assign y_raw = y_ext[CW-1:0];
    assign x_mag = x_raw[CW-1] ? (~x_raw + CW'(1)) : x_raw;
    assign y_mag = y_raw[CW-1] ? (~y_raw + CW'(1)) : y_raw;

    always_comb begin
        in_quad.x_neg  = x_raw[CW-1];
        in_quad.y_neg  = y_raw[CW-1];
        in_quad.x_zero = (x_raw == '0);
        in_quad.y_zero = (y_raw == '0);
    end

    // Front stages
    logic           r_a_valid;
    logic [CW-1:0]  r_a_ax;
    logic [CW-1:0]  r_a_ay;
    c2p_pkg::t_quad r_a_quad;

    logic            r_b_valid;
    logic [2*CW-1:0] r_b_sqx;
    logic [2*CW-1:0] r_b_sqy;
    logic [CW-1:0]   r_b_ax;
    logic [CW-1:0]   r_b_ay;
    c2p_pkg::t_quad  r_b_quad;

    logic           r_c_valid;
    logic [SW-1:0]  r_c_rem;
    logic [CW-1:0]  r_c_ax;
    logic [CW-1:0]  r_c_ay;
    c2p_pkg::t_quad r_c_quad;

    logic a_ready;
    logic b_ready;
    logic c_ready;
    logic out_ready;

    // Cell chain
    logic                 cell_valid [0:NC];
    logic                 cell_ready [0:NC];
    logic signed [XW-1:0] cell_cx    [0:NC];
    logic signed [XW-1:0] cell_cy    [0:NC];
    logic signed [ZW-1:0] cell_z     [0:NC];
    logic [SW-1:0]        cell_rem   [0:NC];
    logic [SW-1:0]        cell_res   [0:NC];
    c2p_pkg::t_quad       cell_quad  [0:NC];

    assign out_ready = !o_valid || !i_stall;
    assign c_ready   = !r_c_valid || cell_ready[0];
    assign b_ready   = !r_b_valid || c_ready;
    assign a_ready   = !r_a_valid || b_ready;
    assign o_stall   = !a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && a_ready) begin
            r_a_ax   <= x_mag;
            r_a_ay   <= y_mag;
            r_a_quad <= in_quad;
        end
        if (r_a_valid && b_ready) begin
            r_b_sqx  <= r_a_ax * r_a_ax;
            r_b_sqy  <= r_a_ay * r_a_ay;
            r_b_ax   <= r_a_ax;
            r_b_ay   <= r_a_ay;
            r_b_quad <= r_a_quad;
        end
        if (r_b_valid && c_ready) begin
            r_c_rem  <= SW'(r_b_sqx) + SW'(r_b_sqy);
            r_c_ax   <= r_b_ax;
            r_c_ay   <= r_b_ay;
            r_c_quad <= r_b_quad;
        end
    end

    assign cell_valid[0] = r_c_valid;
    assign cell_cx[0]    = $signed(XW'({r_c_ax, {c2p_pkg::CORDIC_GUARD{1'b0}}}));
    assign cell_cy[0]    = $signed(XW'({r_c_ay, {c2p_pkg::CORDIC_GUARD{1'b0}}}));
    assign cell_z[0]     = '0;
    assign cell_rem[0]   = r_c_rem;
    assign cell_res[0]   = '0;
    assign cell_quad[0]  = r_c_quad;
    assign cell_ready[NC] = out_ready;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        c2p_cell #(
            .COORD_WIDTH     (COORD_WIDTH),
            .ROTATION_STAGES (ROTATION_STAGES),
            .CELL_INDEX      (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[k]),
            .o_ready (cell_ready[k]),
            .i_cx    (cell_cx[k]),
            .i_cy    (cell_cy[k]),
            .i_z     (cell_z[k]),
            .i_rem   (cell_rem[k]),
            .i_res   (cell_res[k]),
            .i_quad  (cell_quad[k]),
            .o_valid (cell_valid[k+1]),
            .i_ready (cell_ready[k+1]),
            .o_cx    (cell_cx[k+1]),
            .o_cy    (cell_cy[k+1]),
            .o_z     (cell_z[k+1]),
            .o_rem   (cell_rem[k+1]),
            .o_res   (cell_res[k+1]),
            .o_quad  (cell_quad[k+1])
        );
    end

    // Output stage: rounding, quadrant placement and wrap
    c2p_pkg::t_quad       fq;
    logic signed [ZW-1:0] fz;
    logic [FW-1:0]        a_clamp;
    logic [FW-1:0]        a_sel;
    logic [FW-1:0]        full;
    logic [FW:0]          full_rnd;
    logic [AW:0]          deg8;
    logic [SW-1:0]        rad;
    c2p_pkg::t_out_word   n_out;
    logic                 r_o_valid;
    c2p_pkg::t_out_word   r_o_data;

    always_comb begin
        fq = cell_quad[NC];
        fz = cell_z[NC];
        if (fz < 0) begin
            a_clamp = '0;
        end else if (FW'(fz) > c2p_pkg::DEG_90) begin
            a_clamp = c2p_pkg::DEG_90;
        end else begin
            a_clamp = FW'(fz);
        end
        a_sel = fq.y_zero ? '0 : a_clamp;
        if (fq.x_zero) begin
            if (fq.y_zero) begin
                full = '0;
            end else if (fq.y_neg) begin
                full = c2p_pkg::DEG_270;
            end else begin
                full = c2p_pkg::DEG_90;
            end
        end else if (fq.x_neg) begin
            full = fq.y_neg ? (c2p_pkg::DEG_180 + a_sel) : (c2p_pkg::DEG_180 - a_sel);
        end else begin
            full = fq.y_neg ? (c2p_pkg::DEG_360 - a_sel) : a_sel;
        end
        full_rnd = (FW+1)'(full) + c2p_pkg::ROUND_HALF;
        deg8     = full_rnd[FW:8];
        if (deg8 >= c2p_pkg::ANGLE_WRAP) begin
            deg8 = '0;
        end
        rad             = cell_res[NC] + SW'(cell_rem[NC] > cell_res[NC]);
        n_out.radius    = rad[c2p_pkg::RADIUS_WIDTH-1:0];
        n_out.angle_deg = deg8[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_ready) begin
            r_o_valid <= cell_valid[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_valid[NC] && out_ready) begin
            r_o_data <= n_out;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

    // An empty or unstalled output end must never hold back the input side.
    a_no_false_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled although the output end can move");

    a_angle_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.angle_deg < c2p_pkg::ANGLE_WRAP[AW-1:0]))
        else $error("angle word outside [0, 360)");

    a_fill_follows_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_a_valid)
        else $error("accepted word not captured by the first stage");

endmodule

// ----- verif/tb_cartesian_to_polar_degrees_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the cartesian to polar conversion unit
// Sends signed points through the conversion pipeline and checks the radius
// and angle of every output word against an independent fixed-point
// predictor: exact rounded square root and a vectoring CORDIC in degrees.
// Both channels idle and stall at random, with stretches at full rate.
// ----------------------------------------------------------------------------
module tb_cartesian_to_polar_degrees_unit;

    localparam int     CORDIC_STEPS = 16;
    localparam longint UNITS_PER_DEG = 65536;
    localparam longint ANGLE_FULL_TURN = 360 * 256;
    localparam int     RANDOM_POINTS = 800;
    localparam int     MAX_REPORTED = 10;

    localparam longint ATAN_UNITS [0:CORDIC_STEPS-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    c2p_pkg::t_in_word   i_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    c2p_pkg::t_out_word  o_data;

    c2p_pkg::t_out_word  pending_polar [$];
    int                  mismatch_count = 0;
    int                  stall_left = 0;
    bit                  tx_quiet = 1'b0;
    bit                  rx_quiet = 1'b0;

    cartesian_to_polar_degrees_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic c2p_pkg::t_out_word polar_of(input c2p_pkg::t_in_word w);
        longint             ax, ay, cx, cy, dx, dy, z, full, deg8, sum, root, probe;
        bit                 x_neg, y_neg;
        c2p_pkg::t_out_word r;
        x_neg = w.x_coord[c2p_pkg::FIELD_WIDTH-1];
        y_neg = w.y_coord[c2p_pkg::FIELD_WIDTH-1];
        ax = x_neg ? -longint'(w.x_coord) : longint'(w.x_coord);
        ay = y_neg ? -longint'(w.y_coord) : longint'(w.y_coord);

        if (ax == 0) begin
            if (ay == 0)
                full = 0;
            else
                full = (y_neg ? 270 : 90) * UNITS_PER_DEG;
        end else begin
            z = 0;
            if (ay != 0) begin
                cx = ax <<< c2p_pkg::CORDIC_GUARD;
                cy = ay <<< c2p_pkg::CORDIC_GUARD;
                for (int k = 0; k < CORDIC_STEPS; k++) begin
                    dx = cy >>> k;
                    dy = cx >>> k;
                    if (cy >= 0) begin
                        cx = cx + dx;
                        cy = cy - dy;
                        z = z + ATAN_UNITS[k];
                    end else begin
                        cx = cx - dx;
                        cy = cy + dy;
                        z = z - ATAN_UNITS[k];
                    end
                end
                if (z < 0)
                    z = 0;
                if (z > 90 * UNITS_PER_DEG)
                    z = 90 * UNITS_PER_DEG;
            end
            if (!x_neg)
                full = y_neg ? 360 * UNITS_PER_DEG - z : z;
            else
                full = y_neg ? 180 * UNITS_PER_DEG + z : 180 * UNITS_PER_DEG - z;
        end

        deg8 = (full + 128) >>> 8;
        if (deg8 >= ANGLE_FULL_TURN)
            deg8 = 0;

        sum = ax * ax + ay * ay;
        root = 0;
        for (int b = 17; b >= 0; b--) begin
            probe = root | (longint'(1) << b);
            if (probe * probe <= sum)
                root = probe;
        end
        if (sum - root * root > root)
            root = root + 1;

        r.radius = root[c2p_pkg::RADIUS_WIDTH-1:0];
        r.angle_deg = deg8[c2p_pkg::ANGLE_WIDTH-1:0];
        return r;
    endfunction

    // Output words are checked before input words are predicted; the pipeline
    // registers every input word before output, so the order cannot matter.
    always @(posedge i_clk) begin
        c2p_pkg::t_out_word want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_polar.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED)
                        $display("Unexpected output word: radius %0d angle %0d",
                                 o_data.radius, o_data.angle_deg);
                end else begin
                    want = pending_polar.pop_front();
                    if (o_data.radius !== want.radius ||
                        o_data.angle_deg !== want.angle_deg) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTED)
                            $display("Mismatch: expected radius %0d angle %0d, got %0d %0d",
                                     want.radius, want.angle_deg,
                                     o_data.radius, o_data.angle_deg);
                    end
                end
            end
            if (i_valid && !o_stall)
                pending_polar.push_back(polar_of(i_data));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                stall_left = rx_quiet ? 0 : $urandom_range(0, 5);
            else if (stall_left > 0)
                stall_left--;
            i_stall <= (stall_left != 0);
        end
    end

    task automatic send_point(input logic signed [c2p_pkg::FIELD_WIDTH-1:0] x,
                              input logic signed [c2p_pkg::FIELD_WIDTH-1:0] y);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{x_coord: x, y_coord: y};
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic test_axes_and_origin();
        send_point(16'sd0, 16'sd0);
        send_point(16'sd0, 16'sd1);
        send_point(16'sd0, -16'sd1);
        send_point(16'sd0, 16'sd32767);
        send_point(16'sd0, -16'sd32768);
        send_point(16'sd1, 16'sd0);
        send_point(-16'sd1, 16'sd0);
        send_point(16'sd32767, 16'sd0);
        send_point(-16'sd32768, 16'sd0);
    endtask

    task automatic test_extremes();
        send_point(16'sd32767, 16'sd32767);
        send_point(-16'sd32768, -16'sd32768);
        send_point(16'sd32767, -16'sd32768);
        send_point(-16'sd32768, 16'sd32767);
        send_point(-16'sd32768, 16'sd1);
        send_point(-16'sd32768, -16'sd1);
    endtask

    // Includes a point just below the positive x axis, whose angle rounds
    // to a full turn and must wrap to zero.
    task automatic test_quadrants_and_rounding();
        send_point(16'sd1, 16'sd1);
        send_point(-16'sd1, 16'sd1);
        send_point(-16'sd1, -16'sd1);
        send_point(16'sd1, -16'sd1);
        send_point(16'sd32767, -16'sd1);
        send_point(16'sd3, 16'sd4);
        send_point(16'sd1, 16'sd2);
        send_point(-16'sd2, 16'sd3);
    endtask

    task automatic test_random_points();
        logic [31:0]                            raw;
        logic signed [c2p_pkg::FIELD_WIDTH-1:0] x, y;
        int                                     style;
        for (int n = 0; n < RANDOM_POINTS; n++) begin
            if (n % 40 == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            raw = $urandom;
            x = raw[15:0];
            y = raw[31:16];
            style = $urandom_range(0, 19);
            if (style < 3) begin
                x = c2p_pkg::FIELD_WIDTH'($signed($urandom_range(0, 16)) - 8);
                y = c2p_pkg::FIELD_WIDTH'($signed($urandom_range(0, 16)) - 8);
            end else if (style < 5) begin
                if (raw[0])
                    x = c2p_pkg::FIELD_WIDTH'($signed($urandom_range(0, 4)) - 2);
                else
                    y = c2p_pkg::FIELD_WIDTH'($signed($urandom_range(0, 4)) - 2);
            end else if (style < 8) begin
                y = raw[1] ? x : -x;
            end
            send_point(x, y);
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_axes_and_origin();
        test_extremes();
        test_quadrants_and_rounding();
        test_random_points();
        i_valid <= 1'b0;
        while (pending_polar.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_polar.size() == 0)
            $display("** cartesian_to_polar_degrees_unit: PASSED **");
        else
            $display("** cartesian_to_polar_degrees_unit: FAILED **");
        $finish;
    end

    initial begin
        #2000000;
        $display("** cartesian_to_polar_degrees_unit: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/c2p_pkg.sv
rtl/core/c2p_cell.sv
rtl/core/cartesian_to_polar_degrees_unit.sv
verif/tb_cartesian_to_polar_degrees_unit.sv
